### hw/rtl/rgbyuv_pkg.sv
// ----------------------------------------------------------------------------
// rgbyuv_pkg
// Constants and types shared by the RGB to YUV 4:2:0 block converter.
// ----------------------------------------------------------------------------
package rgbyuv_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned LumaSumW = 18;
  localparam int unsigned TermW    = 19;
  localparam int unsigned SumW     = 21;
  localparam int unsigned MagW     = 20;
  localparam int unsigned ChromaW  = 10;

  localparam logic [LumaSumW-1:0] CoefYR    = 18'd299;
  localparam logic [LumaSumW-1:0] CoefYG    = 18'd587;
  localparam logic [LumaSumW-1:0] CoefYB    = 18'd114;
  localparam logic [LumaSumW-1:0] LumaRound = 18'd500;

  localparam logic signed [TermW-1:0] CoefUR = 19'sd147;
  localparam logic signed [TermW-1:0] CoefUG = 19'sd289;
  localparam logic signed [TermW-1:0] CoefUB = 19'sd436;
  localparam logic signed [TermW-1:0] CoefVR = 19'sd615;
  localparam logic signed [TermW-1:0] CoefVG = 19'sd515;
  localparam logic signed [TermW-1:0] CoefVB = 19'sd100;

  // floor(x / 1000) = (x * LumaRecip) >> LumaShift for x < 2^18
  localparam int unsigned         LumaRecipW = 19;
  localparam logic [LumaRecipW-1:0] LumaRecip = 19'd268436;
  localparam int unsigned         LumaShift  = 28;

  // floor(x / 4000) = (x * ChromaRecip) >> ChromaShift for x < 2^20
  localparam int unsigned           ChromaRecipW = 21;
  localparam logic [ChromaRecipW-1:0] ChromaRecip = 21'd1073742;
  localparam int unsigned           ChromaShift  = 32;
  localparam logic [MagW-1:0]       ChromaRound  = 20'd2000;

  localparam logic [PixW-1:0] ChromaOffsetRst = 8'd128;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

### hw/rtl/rgb_to_yuv420_block_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_block_converter
// Converts one 2x2 RGB pixel block per transaction into four luma values and
// one averaged U and V.
// ----------------------------------------------------------------------------
// Input channel in_*: one transaction carries the four RGB triples of a block.
// Output channel out_*: one transaction per input, in order, with four luma
//   values and the block's U and V, each with chroma_offset added.
// cfg_wr_en/cfg_wr_data write chroma_offset; write only while the block holds
//   no transactions in flight.
// Pipeline: five register stages from acceptance to out_tvalid (pixel products,
//   sums and luma reciprocal multiply, chroma rounding, chroma reciprocal
//   multiply, clamp and offset).
// Throughput: one block per cycle while out_tready is high.
// Stall: each stage holds while the next is full and stalled; empty stages
//   still fill, so in_tready stays high until all five stages hold data.
// Reset: all stages empty, chroma_offset returns to 128.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_block_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // red/green/blue top_left, red/green/blue top_right,
  // red/green/blue bottom_left, red/green/blue bottom_right, 8 bits each
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right (8 each),
  // chroma_u (10), chroma_v (10), zero pad (4)
  output logic [55:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int unsigned NumPix = 4;
  localparam int unsigned PixW   = rgbyuv_pkg::PixW;

  rgbyuv_pkg::pipe_en_t en;
  logic [4:0]           valid_r, valid_nxt;
  logic [PixW-1:0]      chroma_offset_r, chroma_offset_nxt;

  logic [rgbyuv_pkg::LumaSumW-1:0]     luma_sum [NumPix];
  logic signed [rgbyuv_pkg::TermW-1:0] u_term   [NumPix];
  logic signed [rgbyuv_pkg::TermW-1:0] v_term   [NumPix];
  logic [PixW-1:0]                     luma     [NumPix];
  logic signed [rgbyuv_pkg::ChromaW-1:0] chroma_u, chroma_v;

  // stage i advances when empty or when stage i+1 advances
  always_comb begin
    en.s5 = !valid_r[4] || out_tready;
    en.s4 = !valid_r[3] || en.s5;
    en.s3 = !valid_r[2] || en.s4;
    en.s2 = !valid_r[1] || en.s3;
    en.s1 = !valid_r[0] || en.s2;

    valid_nxt[0] = en.s1 ? in_tvalid  : valid_r[0];
    valid_nxt[1] = en.s2 ? valid_r[0] : valid_r[1];
    valid_nxt[2] = en.s3 ? valid_r[1] : valid_r[2];
    valid_nxt[3] = en.s4 ? valid_r[2] : valid_r[3];
    valid_nxt[4] = en.s5 ? valid_r[3] : valid_r[4];

    chroma_offset_nxt = cfg_wr_en ? cfg_wr_data : chroma_offset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r         <= '0;
      chroma_offset_r <= rgbyuv_pkg::ChromaOffsetRst;
    end else begin
      valid_r         <= valid_nxt;
      chroma_offset_r <= chroma_offset_nxt;
    end
  end

  assign in_tready  = en.s1;
  assign out_tvalid = valid_r[4];

  for (genvar p = 0; p < NumPix; p++) begin : g_pix
    rgbyuv_pix_mac u_mac (
      .clk      (clk),
      .en       (en.s1),
      .red      (in_tdata[(3*p+0)*PixW +: PixW]),
      .green    (in_tdata[(3*p+1)*PixW +: PixW]),
      .blue     (in_tdata[(3*p+2)*PixW +: PixW]),
      .luma_sum (luma_sum[p]),
      .u_term   (u_term[p]),
      .v_term   (v_term[p])
    );

    rgbyuv_luma_div u_ydiv (
      .clk      (clk),
      .en       (en),
      .luma_sum (luma_sum[p]),
      .luma     (luma[p])
    );
  end

  rgbyuv_chroma_avg u_cu (
    .clk    (clk),
    .en     (en),
    .term0  (u_term[0]),
    .term1  (u_term[1]),
    .term2  (u_term[2]),
    .term3  (u_term[3]),
    .offset (chroma_offset_r),
    .chroma (chroma_u)
  );

  rgbyuv_chroma_avg u_cv (
    .clk    (clk),
    .en     (en),
    .term0  (v_term[0]),
    .term1  (v_term[1]),
    .term2  (v_term[2]),
    .term3  (v_term[3]),
    .offset (chroma_offset_r),
    .chroma (chroma_v)
  );

  assign out_tdata = {4'b0000, chroma_v, chroma_u, luma[3], luma[2], luma[1], luma[0]};

`ifndef SYNTHESIS
  a_ready_when_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r != 5'b11111) |-> in_tready)
    else $error("in_tready low with an empty stage");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while output side accepts");

  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((chroma_u >= -10'sd128) && (chroma_u <= 10'sd382)
                    && (chroma_v >= -10'sd128) && (chroma_v <= 10'sd382)))
    else $error("chroma out of range");

  a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tready) |=> valid_r[0])
    else $error("accepted transaction lost from first stage");
`endif

endmodule

### hw/rtl/rgbyuv_pix_mac.sv
// ----------------------------------------------------------------------------
// rgbyuv_pix_mac
// First stage for one pixel: weighted luma sum and U/V terms in thousandths.
// ----------------------------------------------------------------------------
module rgbyuv_pix_mac (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [rgbyuv_pkg::PixW-1:0]                red,
  input  logic [rgbyuv_pkg::PixW-1:0]                green,
  input  logic [rgbyuv_pkg::PixW-1:0]                blue,
  output logic [rgbyuv_pkg::LumaSumW-1:0]            luma_sum,
  output logic signed [rgbyuv_pkg::TermW-1:0]        u_term,
  output logic signed [rgbyuv_pkg::TermW-1:0]        v_term
);

  logic [rgbyuv_pkg::LumaSumW-1:0]     luma_sum_r, luma_sum_nxt;
  logic signed [rgbyuv_pkg::TermW-1:0] u_term_r, u_term_nxt;
  logic signed [rgbyuv_pkg::TermW-1:0] v_term_r, v_term_nxt;
  logic signed [rgbyuv_pkg::TermW-1:0] r_s, g_s, b_s;

  always_comb begin
    r_s = $signed(rgbyuv_pkg::TermW'(red));
    g_s = $signed(rgbyuv_pkg::TermW'(green));
    b_s = $signed(rgbyuv_pkg::TermW'(blue));
    luma_sum_nxt = rgbyuv_pkg::CoefYR * rgbyuv_pkg::LumaSumW'(red)
                 + rgbyuv_pkg::CoefYG * rgbyuv_pkg::LumaSumW'(green)
                 + rgbyuv_pkg::CoefYB * rgbyuv_pkg::LumaSumW'(blue)
                 + rgbyuv_pkg::LumaRound;
    u_term_nxt = rgbyuv_pkg::CoefUB * b_s - rgbyuv_pkg::CoefUR * r_s
               - rgbyuv_pkg::CoefUG * g_s;
    v_term_nxt = rgbyuv_pkg::CoefVR * r_s - rgbyuv_pkg::CoefVG * g_s
               - rgbyuv_pkg::CoefVB * b_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma_sum_r <= luma_sum_nxt;
      u_term_r   <= u_term_nxt;
      v_term_r   <= v_term_nxt;
    end
  end

  assign luma_sum = luma_sum_r;
  assign u_term   = u_term_r;
  assign v_term   = v_term_r;

endmodule

### hw/rtl/rgbyuv_luma_div.sv
// ----------------------------------------------------------------------------
// rgbyuv_luma_div
// Luma divide by 1000 via reciprocal multiply, then delay to the last stage.
// ----------------------------------------------------------------------------
module rgbyuv_luma_div (
  input  logic                              clk,
  input  rgbyuv_pkg::pipe_en_t              en,
  input  logic [rgbyuv_pkg::LumaSumW-1:0]   luma_sum,
  output logic [rgbyuv_pkg::PixW-1:0]       luma
);

  localparam int unsigned ProdW = rgbyuv_pkg::LumaSumW + rgbyuv_pkg::LumaRecipW;

  logic [ProdW-1:0]              prod_r, prod_nxt;
  logic [rgbyuv_pkg::PixW-1:0]   y3_r, y3_nxt;
  logic [rgbyuv_pkg::PixW-1:0]   y4_r;
  logic [rgbyuv_pkg::PixW-1:0]   y5_r;

  always_comb begin
    prod_nxt = ProdW'(luma_sum) * ProdW'(rgbyuv_pkg::LumaRecip);
    // quotient never exceeds 255, so no clamp
    y3_nxt   = prod_r[rgbyuv_pkg::LumaShift +: rgbyuv_pkg::PixW];
  end

  always_ff @(posedge clk) begin
    if (en.s2) prod_r <= prod_nxt;
    if (en.s3) y3_r   <= y3_nxt;
    if (en.s4) y4_r   <= y3_r;
    if (en.s5) y5_r   <= y4_r;
  end

  assign luma = y5_r;

endmodule

### hw/rtl/rgbyuv_chroma_avg.sv
// ----------------------------------------------------------------------------
// rgbyuv_chroma_avg
// Block sum of one chroma component, divide by 4000 rounded to nearest with ties away from zero,
// clamp and offset.
// ----------------------------------------------------------------------------
module rgbyuv_chroma_avg (
  input  logic                                   clk,
  input  rgbyuv_pkg::pipe_en_t                   en,
  input  logic signed [rgbyuv_pkg::TermW-1:0]    term0,
  input  logic signed [rgbyuv_pkg::TermW-1:0]    term1,
  input  logic signed [rgbyuv_pkg::TermW-1:0]    term2,
  input  logic signed [rgbyuv_pkg::TermW-1:0]    term3,
  input  logic [rgbyuv_pkg::PixW-1:0]            offset,
  output logic signed [rgbyuv_pkg::ChromaW-1:0]  chroma
);

  localparam int unsigned ProdW = rgbyuv_pkg::MagW + rgbyuv_pkg::ChromaRecipW;

  logic signed [rgbyuv_pkg::SumW-1:0]    sum_r, sum_nxt;
  logic signed [rgbyuv_pkg::SumW-1:0]    abs_val;
  logic                                  neg3_r, neg3_nxt;
  logic [rgbyuv_pkg::MagW-1:0]           mag_r, mag_nxt;
  logic                                  neg4_r;
  logic [ProdW-1:0]                      prod_r, prod_nxt;
  logic [rgbyuv_pkg::PixW-1:0]           quot;
  logic signed [rgbyuv_pkg::PixW-1:0]    clamped;
  logic signed [rgbyuv_pkg::ChromaW-1:0] out_r, out_nxt;

  always_comb begin
    sum_nxt = rgbyuv_pkg::SumW'(term0) + rgbyuv_pkg::SumW'(term1)
            + rgbyuv_pkg::SumW'(term2) + rgbyuv_pkg::SumW'(term3);

    neg3_nxt = sum_r[rgbyuv_pkg::SumW-1];
    abs_val  = neg3_nxt ? -sum_r : sum_r;
    mag_nxt  = rgbyuv_pkg::MagW'(abs_val) + rgbyuv_pkg::ChromaRound;

    prod_nxt = ProdW'(mag_r) * ProdW'(rgbyuv_pkg::ChromaRecip);

    quot = prod_r[rgbyuv_pkg::ChromaShift +: rgbyuv_pkg::PixW];
    if (neg4_r) begin
      clamped = (quot > 8'd128) ? -8'sd128 : $signed(-quot);
    end else begin
      clamped = (quot > 8'd127) ? 8'sd127 : $signed(quot);
    end
    out_nxt = $signed({{2{clamped[rgbyuv_pkg::PixW-1]}}, clamped})
            + $signed({2'b00, offset});
  end

  always_ff @(posedge clk) begin
    if (en.s2) sum_r <= sum_nxt;
    if (en.s3) begin
      neg3_r <= neg3_nxt;
      mag_r  <= mag_nxt;
    end
    if (en.s4) begin
      neg4_r <= neg3_r;
      prod_r <= prod_nxt;
    end
    if (en.s5) out_r <= out_nxt;
  end

  assign chroma = out_r;

endmodule
